// ===== rtl/pts_pkg.sv =====
// pts_pkg: types, codes and constants for the priority task scheduler
// no dependencies
`default_nettype none
package pts_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int MAX_LOCK_DEF  = 255;
	localparam int TASK_W        = 5;
	localparam int TICK_W        = 32;
	localparam int LEFT_W        = 26;

	typedef enum logic [3:0] {
		OP_LOAD    = 4'd0,
		OP_TICK    = 4'd1,
		OP_SCHED   = 4'd2,
		OP_WAIT_TO = 4'd3,
		OP_WAIT_PD = 4'd4,
		OP_BLOCK   = 4'd5,
		OP_KILL    = 4'd6,
		OP_RECOVER = 4'd7,
		OP_QUERY   = 4'd8,
		OP_LOCK    = 4'd9,
		OP_UNLOCK  = 4'd10
	} opcode_t;

	localparam logic [1:0] ST_INVALID = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_WAITING = 2'd3;

	localparam logic [1:0] RC_OK     = 2'd0;
	localparam logic [1:0] RC_BAD_ID = 2'd1;
	localparam logic [1:0] RC_LOCKED = 2'd2;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [4:0]  task_number;
		logic [7:0]  task_priority;
		logic [23:0] tick_amount;
		logic [1:0]  initial_state;
	} in_beat_t;

	typedef struct packed {
		logic [4:0] running_task;
		logic       switched;
		logic       switch_wanted;
		logic [1:0] result_code;
		logic [1:0] queried_state;
		logic [7:0] lock_level;
	} out_beat_t;

	// one task table entry
	typedef struct packed {
		logic [1:0]        state;
		logic [7:0]        prio;
		logic [23:0]       period;
		logic [LEFT_W-1:0] period_left;
		logic [LEFT_W-1:0] timeout_left;
		logic              wait_forever;
		logic [TICK_W-1:0] last_scan;
		logic [TICK_W-1:0] touch;
		logic              restore;
		logic              woke;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_SCAN,
		S_FIX,
		S_FIX2,
		S_OUT
	} fsm_t;

	// restore then age one entry
	function automatic entry_t age_entry(entry_t e, logic [TICK_W-1:0] now);
		entry_t r;
		logic [TICK_W-1:0] diff;
		logic signed [34:0] v;
		r = e;
		if (r.state == ST_INVALID && r.restore) begin
			r.restore = 1'b0;
			r.timeout_left = '0;
			r.wait_forever = 1'b0;
			r.woke = 1'b0;
			r.period_left = LEFT_W'(r.period);
			r.state = ST_READY;
		end
		diff = now - r.last_scan;
		if (r.state != ST_INVALID) begin
			r.last_scan = now;
			if (diff != '0 && !diff[TICK_W-1] && r.state != ST_RUNNING && !r.wait_forever) begin
				if (r.timeout_left != '0) begin
					v = 35'(signed'({1'b0, r.timeout_left})) - 35'(signed'({1'b0, diff}));
					if (v <= 0) begin
						r.timeout_left = '0;
						r.woke = 1'b1;
						if (r.state == ST_WAITING) r.state = ST_READY;
					end else begin
						r.timeout_left = LEFT_W'(v);
					end
				end else begin
					v = 35'(signed'({1'b0, r.period_left})) - 35'(signed'({1'b0, diff}));
					if (v <= 0) begin
						v = v + 35'(signed'({1'b0, r.period}));
						if (v <= 0) v = 35'(signed'({1'b0, r.period}));
						if (r.state == ST_WAITING) r.state = ST_READY;
					end
					r.period_left = LEFT_W'(v);
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pts_ram.sv =====
// pts_ram: generic single-port-write, single-read ram, registered read
// no dependencies
`default_nettype none
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/priority_task_scheduler_top.sv =====
// priority_task_scheduler_top: task scheduler with task table in one ram
// depends on pts_pkg and pts_ram
`default_nettype none
// One command beat is taken at a time and gives one result beat. Most commands
// give their result beat after these steps: read the entry, update and write
// back, present. Schedule sweeps the table through the one ram port, one entry
// per cycle, each entry written back in the cycle after its read, then fixes up
// the old and new running entries; the new one is left alone when locked or
// when nothing is picked. The next command beat is taken only once the result
// beat has gone. After reset the table is cleared one entry per cycle before
// the first command is taken; configuration writes are taken always.
module priority_task_scheduler_top #(
	parameter int MAX_TASKS      = pts_pkg::MAX_TASKS_DEF,
	parameter int MAX_LOCK_DEPTH = pts_pkg::MAX_LOCK_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pts_pkg::in_beat_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pts_pkg::out_beat_t    out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [4:0]       cfg_data
);
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int LCAP = (MAX_LOCK_DEPTH < 255) ? MAX_LOCK_DEPTH : 255;
	localparam logic [7:0] LOCK_CAP = 8'(LCAP);
	localparam int TICKW = pts_pkg::TICK_W;

	pts_pkg::fsm_t state_q, state_d;
	pts_pkg::in_beat_t cmd_q;
	pts_pkg::out_beat_t res_q;
	pts_pkg::entry_t rdata, wdata;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [4:0] count_q;
	logic [CW-1:0] live;
	logic [TICKW-1:0] now_q;
	logic [4:0] cur_q;
	logic [7:0] lock_q;
	logic clr_q;
	logic [AW:0] clr_idx_q;
	logic [AW:0] idx_q;
	logic [AW:0] ridx_q;
	logic rvalid_s1;
	logic [AW-1:0] raddr_s1;
	logic [7:0] best_pri_q;
	logic [TICKW-1:0] best_touch_q;
	logic [4:0] best_q;
	logic [4:0] next_cur;
	logic cur_ok;
	logic [AW-1:0] ci;
	logic id_ok;
	logic [AW-1:0] id_a;
	pts_pkg::entry_t aged;

	pts_ram #(.WIDTH(pts_pkg::ENTRY_W), .DEPTH(MAX_TASKS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign live = (32'(count_q) < 32'(MAX_TASKS)) ? CW'(count_q) : CW'(MAX_TASKS);
	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == pts_pkg::S_IDLE) && !clr_q && !out_valid;
	assign out_data = res_q;
	assign cur_ok = cur_q != '0 && 32'(cur_q) <= 32'(MAX_TASKS);
	assign ci = cur_ok ? AW'(cur_q - 5'd1) : '0;
	assign id_ok = cmd_q.task_number != '0 && 32'(cmd_q.task_number) <= 32'(live);
	assign id_a = AW'(cmd_q.task_number - 5'd1);
	assign aged = pts_pkg::age_entry(rdata, now_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::S_IDLE;
			count_q <= '0;
			now_q <= '0;
			cur_q <= '0;
			lock_q <= '0;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) count_q <= cfg_data;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (32'(clr_idx_q) == MAX_TASKS - 1) clr_q <= 1'b0;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == pts_pkg::S_OUT) begin
				out_valid <= 1'b1;
				cur_q <= next_cur;
				lock_q <= res_q.lock_level;
				if (cmd_q.opcode == pts_pkg::OP_TICK) now_q <= now_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) cmd_q <= in_data;
		rvalid_s1 <= state_q == pts_pkg::S_SCAN && 32'(ridx_q) < 32'(live);
		if (state_q == pts_pkg::S_SCAN && 32'(ridx_q) < 32'(live)) begin
			raddr_s1 <= AW'(ridx_q);
			ridx_q <= ridx_q + 1'b1;
		end
		if (state_q == pts_pkg::S_SCAN && rvalid_s1) begin
			idx_q <= idx_q + 1'b1;
			if (aged.state == pts_pkg::ST_READY || aged.state == pts_pkg::ST_RUNNING) begin
				if (aged.prio < best_pri_q) begin
					best_pri_q <= aged.prio;
					best_touch_q <= aged.touch;
					best_q <= 5'(raddr_s1) + 5'd1;
				end else if (aged.prio == best_pri_q && aged.touch < best_touch_q) begin
					best_touch_q <= aged.touch;
					best_q <= 5'(raddr_s1) + 5'd1;
				end
			end
		end
		if (state_q == pts_pkg::S_IDLE) begin
			idx_q <= '0;
			ridx_q <= '0;
			best_pri_q <= 8'd255;
			best_touch_q <= '1;
			best_q <= '0;
		end
		if (state_q == pts_pkg::S_RD) begin
			res_q <= pts_pkg::out_beat_t'{running_task: cur_q, switched: 1'b0,
				switch_wanted: 1'b0, result_code: pts_pkg::RC_OK,
				queried_state: pts_pkg::ST_INVALID, lock_level: lock_q};
		end
		if (state_q == pts_pkg::S_FIX) begin
			unique case (cmd_q.opcode) inside
				pts_pkg::OP_LOAD, pts_pkg::OP_RECOVER:
					if (!id_ok) res_q.result_code <= pts_pkg::RC_BAD_ID;
					else if (cmd_q.opcode == pts_pkg::OP_RECOVER) res_q.switch_wanted <= 1'b1;
				pts_pkg::OP_QUERY:
					if (!id_ok) res_q.result_code <= pts_pkg::RC_BAD_ID;
					else res_q.queried_state <= rdata.state;
				pts_pkg::OP_TICK: res_q.switch_wanted <= lock_q == '0;
				pts_pkg::OP_WAIT_TO, pts_pkg::OP_WAIT_PD, pts_pkg::OP_BLOCK:
					if (lock_q != '0) res_q.result_code <= pts_pkg::RC_LOCKED;
					else if (cur_ok) res_q.switch_wanted <= 1'b1;
				pts_pkg::OP_KILL: res_q.switch_wanted <= 1'b1;
				pts_pkg::OP_LOCK:
					if (lock_q < LOCK_CAP) res_q.lock_level <= lock_q + 8'd1;
				pts_pkg::OP_UNLOCK: begin
					if (lock_q > 8'd1) res_q.lock_level <= lock_q - 8'd1;
					else begin
						res_q.lock_level <= '0;
						res_q.switch_wanted <= 1'b1;
					end
				end
				pts_pkg::OP_SCHED: begin
					if (lock_q == '0) begin
						res_q.running_task <= best_q;
						res_q.switched <= best_q != cur_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		next_cur = res_q.running_task;
	end

	// ram port control and sequencing
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		raddr = '0;
		if (clr_q) begin
			we = 1'b1;
			waddr = AW'(clr_idx_q);
			wdata = '0;
		end
		unique case (state_q)
			pts_pkg::S_IDLE:
				if (in_valid && in_ready) state_d = pts_pkg::S_RD;
			pts_pkg::S_RD: begin
				if (cmd_q.opcode == pts_pkg::OP_SCHED) begin
					state_d = pts_pkg::S_SCAN;
				end else begin
					raddr = (cmd_q.opcode == pts_pkg::OP_LOAD || cmd_q.opcode == pts_pkg::OP_RECOVER
						|| cmd_q.opcode == pts_pkg::OP_QUERY) ? id_a : ci;
					state_d = pts_pkg::S_FIX;
				end
			end
			pts_pkg::S_SCAN: begin
				raddr = AW'(ridx_q);
				if (rvalid_s1) begin
					we = 1'b1;
					waddr = raddr_s1;
					wdata = aged;
				end
				if (32'(idx_q) >= 32'(live) && !(32'(ridx_q) < 32'(live)))
					state_d = pts_pkg::S_FIX;
				raddr = (32'(ridx_q) < 32'(live)) ? AW'(ridx_q) : ci;
			end
			pts_pkg::S_FIX: begin
				// rdata holds the addressed entry (or old current for schedule)
				state_d = pts_pkg::S_OUT;
				unique case (cmd_q.opcode) inside
					pts_pkg::OP_LOAD: if (id_ok) begin
						we = 1'b1;
						waddr = id_a;
						wdata.state = cmd_q.initial_state;
						wdata.prio = cmd_q.task_priority;
						wdata.period = cmd_q.tick_amount;
						wdata.period_left = pts_pkg::LEFT_W'(cmd_q.tick_amount);
						wdata.timeout_left = '0;
						wdata.wait_forever = 1'b0;
						wdata.restore = 1'b0;
						wdata.woke = 1'b0;
						wdata.last_scan = now_q;
						wdata.touch = now_q;
					end
					pts_pkg::OP_RECOVER: if (id_ok) begin
						we = 1'b1;
						waddr = id_a;
						wdata.restore = 1'b1;
						wdata.state = pts_pkg::ST_INVALID;
					end
					pts_pkg::OP_WAIT_TO, pts_pkg::OP_WAIT_PD, pts_pkg::OP_BLOCK:
						if (lock_q == '0 && cur_ok) begin
							we = 1'b1;
							waddr = ci;
							if (cmd_q.opcode == pts_pkg::OP_WAIT_TO) begin
								wdata.timeout_left = pts_pkg::LEFT_W'(cmd_q.tick_amount);
								wdata.wait_forever = 1'b0;
							end else if (cmd_q.opcode == pts_pkg::OP_BLOCK) begin
								wdata.timeout_left = '0;
								wdata.wait_forever = 1'b1;
							end
							wdata.state = pts_pkg::ST_WAITING;
						end
					pts_pkg::OP_KILL: if (cur_ok) begin
						we = 1'b1;
						waddr = ci;
						wdata.state = pts_pkg::ST_INVALID;
					end
					pts_pkg::OP_SCHED: begin
						// demote old running task, then fix new one
						if (lock_q == '0 && best_q != cur_q && cur_ok
							&& rdata.state == pts_pkg::ST_RUNNING) begin
							we = 1'b1;
							waddr = ci;
							wdata.state = pts_pkg::ST_READY;
						end
						raddr = AW'(best_q - 5'd1);
						if (lock_q == '0 && best_q != '0) state_d = pts_pkg::S_FIX2;
					end
					default: ;
				endcase
			end
			pts_pkg::S_FIX2: begin
				we = 1'b1;
				waddr = AW'(best_q - 5'd1);
				wdata.touch = now_q;
				if (best_q != cur_q) wdata.state = pts_pkg::ST_RUNNING;
				state_d = pts_pkg::S_OUT;
			end
			pts_pkg::S_OUT: state_d = pts_pkg::S_IDLE;
			default: state_d = pts_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
